// ===== src/hrlt_pkg.sv =====
// Types, constants and helper functions shared by the request line tokenizer.
package hrlt_pkg;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SKIP,
    PH_RES,
    PH_PARAM,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_METHOD_CHAR = 3'd0,
    KIND_RES_CHAR    = 3'd1,
    KIND_PARAM_CHAR  = 3'd2,
    KIND_PARAM_END   = 3'd3,
    KIND_LINE_END    = 3'd4,
    KIND_BAD_ESC     = 3'd5
  } kind_t;

  localparam logic [2:0] MIME_NONE = 3'd0;
  localparam logic [2:0] MIME_HTML = 3'd1;
  localparam logic [2:0] MIME_CSS  = 3'd2;
  localparam logic [2:0] MIME_JS   = 3'd3;
  localparam logic [2:0] MIME_JPEG = 3'd4;
  localparam logic [2:0] MIME_PNG  = 3'd5;
  localparam logic [2:0] MIME_ICON = 3'd6;

  localparam logic [1:0] ESC_IDLE   = 2'd0;
  localparam logic [1:0] ESC_FIRST  = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;

  // Extensions packed with the first character in the lowest byte.
  localparam logic [31:0] EXT_HTML = 32'h6C6D7468;
  localparam logic [31:0] EXT_CSS  = 32'h00737363;
  localparam logic [31:0] EXT_JS   = 32'h0000736A;
  localparam logic [31:0] EXT_JPG  = 32'h0067706A;
  localparam logic [31:0] EXT_JPEG = 32'h6765706A;
  localparam logic [31:0] EXT_PNG  = 32'h00676E70;
  localparam logic [31:0] EXT_ICO  = 32'h006F6369;

  localparam int MAX_RESULTS = 3;

  typedef logic [1:0] res_cnt_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  method_count;
    logic        get_match;
    logic [1:0]  escape_step;
    logic [2:0]  escape_digit;
    logic [7:0]  param_counter;
    logic [2:0]  resource_count;
    logic        dot_seen;
    logic        last_dot_at_start;
    logic [31:0] ext_chars;
    logic [2:0]  ext_count;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:             PH_METHOD,
    method_count:      4'd0,
    get_match:         1'b1,
    escape_step:       ESC_IDLE,
    escape_digit:      3'd0,
    param_counter:     8'd0,
    resource_count:    3'd0,
    dot_seen:          1'b0,
    last_dot_at_start: 1'b0,
    ext_chars:         32'd0,
    ext_count:         3'd0
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_out;
    logic [7:0] param_number;
    logic [7:0] param_total;
    logic       method_is_get;
    logic       client_side;
    logic [2:0] mime_class;
  } result_t;

  localparam result_t RESULT_ZERO = '{
    kind: KIND_METHOD_CHAR, char_out: 8'd0, param_number: 8'd0, param_total: 8'd0,
    method_is_get: 1'b0, client_side: 1'b0, mime_class: MIME_NONE
  };

  // Returns {bad, byte}; bad is set when the code is not in the table.
  function automatic logic [8:0] decode_pair(logic [2:0] d1, logic [7:0] d2);
    logic [3:0] lo;
    logic       ok;
    lo = 4'd0;
    ok = 1'b0;
    if (d2 >= 8'h30 && d2 <= 8'h39) begin
      lo = d2[3:0];
      ok = 1'b1;
    end else if (d2 >= 8'h41 && d2 <= 8'h46) begin
      lo = 4'(d2[3:0] + 4'd9);
      ok = 1'b1;
    end
    if (ok) begin
      case (d1)
        3'd2: ok = (lo <= 4'd9) || (lo == 4'd11) || (lo == 4'd12) || (lo == 4'd15);
        3'd3: ok = (lo >= 4'd10);
        3'd4: ok = (lo == 4'd0);
        3'd5: ok = (lo >= 4'd11) && (lo <= 4'd14);
        3'd6: ok = (lo == 4'd0);
        3'd7: ok = (lo >= 4'd11) && (lo <= 4'd14);
        default: ok = 1'b0;
      endcase
    end
    return {~ok, 1'b0, d1, lo};
  endfunction

  function automatic logic [2:0] mime_of(parse_state_t s);
    logic [2:0] m;
    m = MIME_NONE;
    if (s.resource_count >= 3'd4 && s.dot_seen && !s.last_dot_at_start) begin
      if (s.ext_count == 3'd4 && s.ext_chars == EXT_HTML)      m = MIME_HTML;
      else if (s.ext_count == 3'd3 && s.ext_chars == EXT_CSS)  m = MIME_CSS;
      else if (s.ext_count == 3'd2 && s.ext_chars == EXT_JS)   m = MIME_JS;
      else if (s.ext_count == 3'd3 && s.ext_chars == EXT_JPG)  m = MIME_JPEG;
      else if (s.ext_count == 3'd4 && s.ext_chars == EXT_JPEG) m = MIME_JPEG;
      else if (s.ext_count == 3'd3 && s.ext_chars == EXT_PNG)  m = MIME_PNG;
      else if (s.ext_count == 3'd3 && s.ext_chars == EXT_ICO)  m = MIME_ICON;
    end
    return m;
  endfunction

  function automatic logic [7:0] get_char(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_G;
      2'd1:    c = CH_E;
      default: c = CH_T;
    endcase
    return c;
  endfunction

endpackage

// ===== src/hrlt_step.sv =====
// Per-byte parse step: next parser state and up to three results for one item.
module hrlt_step #(
  parameter int MAX_METHOD_LEN = 10
) (
  input  hrlt_pkg::parse_state_t state_in,
  input  logic [7:0]             byte_in,
  input  logic                   first_byte,
  output hrlt_pkg::parse_state_t state_nxt,
  output hrlt_pkg::result_t      res [hrlt_pkg::MAX_RESULTS],
  output hrlt_pkg::res_cnt_t     res_cnt
);
  import hrlt_pkg::*;

  parse_state_t s;
  logic         is_space;
  logic         is_amp;
  logic         is_get;
  logic [8:0]   decoded;
  logic [7:0]   lower;
  logic [2:0]   mime;
  logic         cside;

  assign s        = first_byte ? PARSE_RESET : state_in;
  assign is_space = (byte_in == CH_SPACE);
  assign is_amp   = (byte_in == CH_AMP);
  assign is_get   = (s.method_count == 4'd3) && s.get_match;
  assign decoded  = decode_pair(s.escape_digit, byte_in);
  assign lower    = (byte_in >= 8'h41 && byte_in <= 8'h5A) ? (byte_in + 8'd32) : byte_in;
  assign mime     = mime_of(s);
  assign cside    = (s.resource_count == 3'd0) || s.dot_seen;

  // Next state.
  always_comb begin
    state_nxt = s;
    unique case (s.phase)
      PH_METHOD: begin
        if (is_space) begin
          state_nxt.phase = is_get ? PH_SKIP : PH_DONE;
        end else if (s.method_count < 4'(MAX_METHOD_LEN)) begin
          if (s.method_count >= 4'd3 || byte_in != get_char(s.method_count[1:0])) begin
            state_nxt.get_match = 1'b0;
          end
          state_nxt.method_count = s.method_count + 4'd1;
        end else begin
          state_nxt.get_match = 1'b0;
        end
      end
      PH_SKIP: begin
        state_nxt.phase = PH_RES;
      end
      PH_RES: begin
        if (is_space) begin
          state_nxt.phase = PH_DONE;
        end else if (byte_in == CH_QMARK) begin
          state_nxt.phase         = PH_PARAM;
          state_nxt.param_counter = 8'd0;
        end else begin
          if (byte_in == CH_DOT) begin
            state_nxt.dot_seen          = 1'b1;
            state_nxt.last_dot_at_start = (s.resource_count == 3'd0);
            state_nxt.ext_chars         = 32'd0;
            state_nxt.ext_count         = 3'd0;
          end else begin
            if (s.ext_count < 3'd4) begin
              state_nxt.ext_chars[s.ext_count[1:0]*8 +: 8] = lower;
            end
            if (s.ext_count < 3'd5) begin
              state_nxt.ext_count = s.ext_count + 3'd1;
            end
          end
          if (s.resource_count < 3'd4) begin
            state_nxt.resource_count = s.resource_count + 3'd1;
          end
        end
      end
      PH_PARAM: begin
        if (is_space || is_amp) begin
          state_nxt.escape_step = ESC_IDLE;
          if (is_space) begin
            state_nxt.phase = PH_DONE;
          end else if (s.param_counter != 8'hFF) begin
            state_nxt.param_counter = s.param_counter + 8'd1;
          end
        end else if (s.escape_step == ESC_FIRST) begin
          if (byte_in >= 8'h32 && byte_in <= 8'h37) begin
            state_nxt.escape_digit = byte_in[2:0];
            state_nxt.escape_step  = ESC_SECOND;
          end else begin
            state_nxt.escape_step = ESC_IDLE;
          end
        end else if (s.escape_step == ESC_SECOND) begin
          state_nxt.escape_step = ESC_IDLE;
        end else if (byte_in == CH_PCT) begin
          state_nxt.escape_step = ESC_FIRST;
        end
      end
      PH_DONE: begin
        state_nxt = s;
      end
      default: begin
        state_nxt = s;
      end
    endcase
  end

  // Results, appended in the order they leave the block.
  always_comb begin
    result_t  r;
    res_cnt_t n;
    r = RESULT_ZERO;
    n = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = RESULT_ZERO;
    end
    unique case (s.phase)
      PH_METHOD: begin
        if (is_space) begin
          if (!is_get) begin
            r = RESULT_ZERO;
            r.kind        = KIND_LINE_END;
            r.client_side = 1'b1;
            res[n] = r;
            n = n + 2'd1;
          end
        end else if (s.method_count < 4'(MAX_METHOD_LEN)) begin
          r = RESULT_ZERO;
          r.kind     = KIND_METHOD_CHAR;
          r.char_out = byte_in;
          res[n] = r;
          n = n + 2'd1;
        end
      end
      PH_RES: begin
        if (is_space) begin
          r = RESULT_ZERO;
          r.kind          = KIND_LINE_END;
          r.method_is_get = 1'b1;
          r.client_side   = cside;
          r.mime_class    = mime;
          res[n] = r;
          n = n + 2'd1;
        end else if (byte_in != CH_QMARK) begin
          r = RESULT_ZERO;
          r.kind     = KIND_RES_CHAR;
          r.char_out = byte_in;
          res[n] = r;
          n = n + 2'd1;
        end
      end
      PH_PARAM: begin
        if (is_space || is_amp) begin
          // A separator inside an escape first reports the broken escape.
          if (s.escape_step != ESC_IDLE) begin
            r = RESULT_ZERO;
            r.kind         = KIND_BAD_ESC;
            r.param_number = s.param_counter;
            res[n] = r;
            n = n + 2'd1;
          end
          r = RESULT_ZERO;
          r.kind         = KIND_PARAM_END;
          r.param_number = s.param_counter;
          res[n] = r;
          n = n + 2'd1;
          if (is_space) begin
            r = RESULT_ZERO;
            r.kind          = KIND_LINE_END;
            r.param_total   = (s.param_counter != 8'hFF) ? s.param_counter + 8'd1 : 8'hFF;
            r.method_is_get = 1'b1;
            r.client_side   = cside;
            r.mime_class    = mime;
            res[n] = r;
            n = n + 2'd1;
          end
        end else if (s.escape_step == ESC_FIRST) begin
          if (!(byte_in >= 8'h32 && byte_in <= 8'h37)) begin
            r = RESULT_ZERO;
            r.kind         = KIND_BAD_ESC;
            r.param_number = s.param_counter;
            res[n] = r;
            n = n + 2'd1;
          end
        end else if (s.escape_step == ESC_SECOND) begin
          r = RESULT_ZERO;
          r.kind         = decoded[8] ? KIND_BAD_ESC : KIND_PARAM_CHAR;
          r.char_out     = decoded[8] ? 8'd0 : decoded[7:0];
          r.param_number = s.param_counter;
          res[n] = r;
          n = n + 2'd1;
        end else if (byte_in != CH_PCT) begin
          r = RESULT_ZERO;
          r.kind         = KIND_PARAM_CHAR;
          r.char_out     = (byte_in == CH_PLUS) ? CH_SPACE : byte_in;
          r.param_number = s.param_counter;
          res[n] = r;
          n = n + 2'd1;
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase
    res_cnt = n;
  end

endmodule

// ===== src/hrlt_outbuf.sv =====
// Result register bank that hands the results of one item out one per cycle while the receiver is ready.
module hrlt_outbuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  hrlt_pkg::result_t      load_res [hrlt_pkg::MAX_RESULTS],
  input  hrlt_pkg::res_cnt_t     load_cnt,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hrlt_pkg::result_t      out_res,
  output logic                   out_last
);
  import hrlt_pkg::*;

  result_t  buf_r [MAX_RESULTS];
  res_cnt_t left_r;
  res_cnt_t left_nxt;
  res_cnt_t ptr_r;
  res_cnt_t ptr_nxt;
  logic     take;

  assign out_valid = (left_r != 2'd0);
  assign out_last  = (left_r == 2'd1);
  assign out_res   = buf_r[ptr_r];
  assign take      = out_valid && out_ready;
  // The bank can take a new item when it is empty or once its last result leaves in this cycle.
  assign free      = !out_valid || (take && out_last);

  always_comb begin
    left_nxt = left_r;
    ptr_nxt  = ptr_r;
    if (load) begin
      left_nxt = load_cnt;
      ptr_nxt  = 2'd0;
    end else if (take) begin
      left_nxt = left_r - 2'd1;
      ptr_nxt  = ptr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 2'd0;
      ptr_r  <= 2'd0;
    end else begin
      left_r <= left_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        buf_r[i] <= load_res[i];
      end
    end
  end

endmodule

// ===== src/http_request_line_tokenizer.sv =====
// Top level of the HTTP request line tokenizer with query parameter decoding.
//
// Input channel (in_*): one request line byte per item in in_tdata, with
// in_tuser set on the first byte of a new request, which restarts parsing.
// Result channel (out_*): method, resource and parameter characters, parameter
// end and bad escape markers, and a line end summary. out_tuser carries the
// result kind and out_tlast marks the final result caused by one input byte.
// An accepted byte sits in an input register until the result registers are
// free; the parse step then updates the parser state and loads its zero to
// three results into the result registers, from which they are handed out.
// A byte that causes at most one result is accepted every cycle while the
// receiver takes each result; a byte that causes more results holds the
// result registers, so the next byte is parsed when the last of them is taken.
// Reset returns the parser to the method phase and empties both registers;
// in_tready stays low while reset is asserted.
// When the receiver stalls, the current result holds and the input register
// fills, after which in_tready drops until results drain.
module http_request_line_tokenizer #(
  parameter int MAX_METHOD_LEN = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tuser,   // [0] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] char_out, [15:8] param_number,
                                  // [23:16] param_total, [24] method_is_get,
                                  // [25] client_side, [28:26] mime_class, rest zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);
  import hrlt_pkg::*;

  logic         in_valid_r;
  logic         in_valid_nxt;
  logic [7:0]   byte_r;
  logic         first_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  result_t      step_res [MAX_RESULTS];
  res_cnt_t     step_cnt;
  logic         buf_free;
  logic         parse;
  logic         accept;
  result_t      cur_res;

  assign parse     = in_valid_r && buf_free;
  assign in_tready = rst_n && (!in_valid_r || parse);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (parse) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= PARSE_RESET;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (parse) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r  <= in_tdata;
      first_r <= in_tuser;
    end
  end

  hrlt_step #(
    .MAX_METHOD_LEN(MAX_METHOD_LEN)
  ) u_step (
    .state_in  (state_r),
    .byte_in   (byte_r),
    .first_byte(first_r),
    .state_nxt (state_nxt),
    .res       (step_res),
    .res_cnt   (step_cnt)
  );

  hrlt_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (parse),
    .load_res (step_res),
    .load_cnt (step_cnt),
    .free     (buf_free),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (cur_res),
    .out_last (out_tlast)
  );

  assign out_tuser = cur_res.kind;
  assign out_tdata = {3'b000, cur_res.mime_class, cur_res.client_side,
                      cur_res.method_is_get, cur_res.param_total,
                      cur_res.param_number, cur_res.char_out};

endmodule
